// ----- hdl/bpmd_pkg.sv -----
// Shared types and constants for the balance PID motor drive.
`timescale 1ns / 1ps
package bpmd_pkg;

  // Defaults for the top-level parameters
  localparam int DUTY_BITS_DEF      = 10;
  localparam int FALL_LIMIT_DEG_DEF = 45;

  // Milliseconds per second, used to turn period_ms into dt
  localparam int MS_PER_SECOND = 1000;

  // Register index codes on the configuration port
  localparam logic [3:0] REG_PROP_GAIN    = 4'd0;
  localparam logic [3:0] REG_INTEG_GAIN   = 4'd1;
  localparam logic [3:0] REG_DERIV_GAIN   = 4'd2;
  localparam logic [3:0] REG_SPEED_FACTOR = 4'd3;
  localparam logic [3:0] REG_TARGET_ANGLE = 4'd4;
  localparam logic [3:0] REG_MIN_DUTY     = 4'd5;
  localparam logic [3:0] REG_MAX_OUTPUT   = 4'd6;
  localparam logic [3:0] REG_PERIOD_MS    = 4'd7;

  // Register reset values
  localparam logic [17:0]        PROP_GAIN_RST    = 18'd22528;
  localparam logic [17:0]        INTEG_GAIN_RST   = 18'd13568;
  localparam logic [17:0]        DERIV_GAIN_RST   = 18'd166;
  localparam logic [8:0]         SPEED_FACTOR_RST = 9'd218;
  localparam logic signed [15:0] TARGET_ANGLE_RST = 16'sd1664;
  localparam logic [9:0]         MIN_DUTY_RST     = 10'd300;
  localparam logic [9:0]         MAX_OUTPUT_RST   = 10'd600;
  localparam logic [7:0]         PERIOD_MS_RST    = 8'd22;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_IMUL1,
    ST_IMUL2,
    ST_IDIV,
    ST_IACC,
    ST_PMUL,
    ST_DMUL1,
    ST_DMUL2,
    ST_DDIV,
    ST_DSUB,
    ST_DRV,
    ST_DUTY,
    ST_FIN
  } state_t;

endpackage

// ----- hdl/balance_pid_motor_drive.sv -----
// Top level: bit-serial PID balance controller with clamp and motor duty.
`timescale 1ns / 1ps
// Each sample transaction (in_tuser = 0) runs through one shared shift-add
// multiplier (one multiplier bit per cycle) and one restoring divider (one
// quotient bit per cycle) in order: integral term (multiply, multiply, divide,
// then update the integrator), proportional term (multiply), derivative term
// (multiply, multiply, divide, then subtract), clamp, duty scaling (multiply)
// and the load of the output register. A sample is accepted only in the idle
// state, so the next transaction waits until the result is loaded. A clear
// transaction (in_tuser = 1) zeroes the integrator and goes straight to the
// final state, which loads an all-zero result. A result that is not taken
// stalls the last stage; a new transaction is accepted while the previous
// result still waits on the output register. Configuration writes are always
// accepted and take effect at once, also on a sample in progress.
module balance_pid_motor_drive #(
  parameter int DUTY_BITS      = bpmd_pkg::DUTY_BITS_DEF,
  parameter int FALL_LIMIT_DEG = bpmd_pkg::FALL_LIMIT_DEG_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [15:0]                           in_tdata,   // tilt
  input  logic [0:0]                            in_tuser,   // cmd
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // drive[10:0], reverse, duty[DUTY_BITS-1:0], fallen, zero pad
  output logic [((13 + DUTY_BITS + 7) / 8) * 8 - 1:0] out_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [3:0]                            cfg_index,
  input  logic [17:0]                           cfg_data
);
  import bpmd_pkg::*;

  localparam int OUT_W = ((13 + DUTY_BITS + 7) / 8) * 8;
  localparam logic [31:0] DUTY_MAX = 32'((64'd1 << DUTY_BITS) - 64'd1);
  localparam logic signed [16:0] FALL_Q = 17'(FALL_LIMIT_DEG * 256);
  localparam logic [17:0] MS_K = 18'(MS_PER_SECOND);

  // Configuration registers
  logic [17:0]        kp_r, ki_r, kd_r;
  logic [8:0]         sf_r;
  logic signed [15:0] target_r;
  logic [9:0]         min_duty_r, max_out_r;
  logic [7:0]         period_r;

  // Controller state
  logic signed [26:0] integ_r;
  logic signed [15:0] last_tilt_r;

  // Sequencer and serial datapath
  state_t             state_r, state_nxt;
  logic [5:0]         cnt_r;
  logic [44:0]        acc_r, mc_r;
  logic [17:0]        mp_r;
  logic [9:0]         rem_r, dvs_r;
  logic [16:0]        err_mag_r, diff_mag_r;
  logic               err_neg_r, diff_neg_r, fallen_r, clr_r;
  logic signed [47:0] sum_r;
  logic [10:0]        drive_r;
  logic               rev_r;

  // Output register
  logic               out_valid_r;
  logic [OUT_W-1:0]   out_data_r;

  logic               in_acc, cnt_last, fin_go;
  logic [7:0]         per_eff;
  logic signed [15:0] tilt;
  logic signed [16:0] err_s, diff_s;
  logic [44:0]        mul_add;
  logic [10:0]        div_try, div_sub;
  logic               div_ge;
  logic signed [34:0] inc_s, isum_s, ilim_s;
  logic signed [26:0] integ_cl;
  logic signed [47:0] p_s, d_s;
  logic [47:0]        sum_abs;
  logic [30:0]        q16;
  logic [9:0]         drv_mag, v_mag;
  logic [10:0]        scaled;
  logic [DUTY_BITS-1:0] duty_v;

  // Handshake and ports
  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    in_acc     = in_tvalid && in_tready;
    fin_go     = !out_valid_r || out_tready;
    cnt_last   = (cnt_r == 6'd0);
    cfg_ready  = 1'b1;
    out_tvalid = out_valid_r;
    out_tdata  = out_data_r;
  end

  // Operand preparation
  always_comb begin
    per_eff = (period_r == 8'd0) ? 8'd1 : period_r;
    tilt    = $signed(in_tdata);
    err_s   = 17'(target_r) - 17'(tilt);
    diff_s  = 17'(tilt) - 17'(last_tilt_r);
  end

  // Serial multiply step and restoring divide step
  always_comb begin
    mul_add = acc_r + (mp_r[0] ? mc_r : 45'd0);
    div_try = {rem_r, acc_r[44]};
    div_ge  = (div_try >= {1'b0, dvs_r});
    div_sub = div_try - {1'b0, dvs_r};
  end

  // Integral update with clamp
  always_comb begin
    inc_s  = err_neg_r ? -$signed({1'b0, acc_r[33:0]}) : $signed({1'b0, acc_r[33:0]});
    isum_s = 35'(integ_r) + inc_s;
    ilim_s = $signed({9'd0, max_out_r, 16'd0});
    priority if (isum_s > ilim_s) begin
      integ_cl = 27'(ilim_s);
    end else if (isum_s < -ilim_s) begin
      integ_cl = 27'(-ilim_s);
    end else begin
      integ_cl = 27'(isum_s);
    end
  end

  // Term signs, output truncation and clamp, duty saturation
  always_comb begin
    p_s     = $signed({13'd0, mul_add[34:0]});
    if (err_neg_r) begin
      p_s = -p_s;
    end
    d_s     = $signed({3'd0, acc_r});
    if (diff_neg_r) begin
      d_s = -d_s;
    end
    sum_abs = sum_r[47] ? 48'(-sum_r) : 48'(sum_r);
    q16     = sum_abs[46:16];
    drv_mag = (q16 > 31'(max_out_r)) ? max_out_r : q16[9:0];
    v_mag   = (drv_mag > min_duty_r) ? drv_mag : min_duty_r;
    scaled  = acc_r[18:8];
    duty_v  = (32'(scaled) > DUTY_MAX) ? '1 : DUTY_BITS'(scaled);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = in_tuser[0] ? ST_FIN : ST_IMUL1;
      ST_IMUL1: if (cnt_last) state_nxt = ST_IMUL2;
      ST_IMUL2: if (cnt_last) state_nxt = ST_IDIV;
      ST_IDIV:  if (cnt_last) state_nxt = ST_IACC;
      ST_IACC:  state_nxt = ST_PMUL;
      ST_PMUL:  if (cnt_last) state_nxt = ST_DMUL1;
      ST_DMUL1: if (cnt_last) state_nxt = ST_DMUL2;
      ST_DMUL2: if (cnt_last) state_nxt = ST_DDIV;
      ST_DDIV:  if (cnt_last) state_nxt = ST_DSUB;
      ST_DSUB:  state_nxt = ST_DRV;
      ST_DRV:   state_nxt = ST_DUTY;
      ST_DUTY:  if (cnt_last) state_nxt = ST_FIN;
      ST_FIN:   if (fin_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control registers: state, configuration, controller state, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      kp_r        <= PROP_GAIN_RST;
      ki_r        <= INTEG_GAIN_RST;
      kd_r        <= DERIV_GAIN_RST;
      sf_r        <= SPEED_FACTOR_RST;
      target_r    <= TARGET_ANGLE_RST;
      min_duty_r  <= MIN_DUTY_RST;
      max_out_r   <= MAX_OUTPUT_RST;
      period_r    <= PERIOD_MS_RST;
      integ_r     <= '0;
      last_tilt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // take configuration writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_PROP_GAIN:    kp_r       <= cfg_data;
          REG_INTEG_GAIN:   ki_r       <= cfg_data;
          REG_DERIV_GAIN:   kd_r       <= cfg_data;
          REG_SPEED_FACTOR: sf_r       <= cfg_data[8:0];
          REG_TARGET_ANGLE: target_r   <= $signed(cfg_data[15:0]);
          REG_MIN_DUTY:     min_duty_r <= cfg_data[9:0];
          REG_MAX_OUTPUT:   max_out_r  <= cfg_data[9:0];
          REG_PERIOD_MS:    period_r   <= cfg_data[7:0];
          default: ;
        endcase
      end
      // clear or advance the controller state
      if (in_acc && in_tuser[0]) begin
        integ_r <= '0;
      end else if (in_acc) begin
        last_tilt_r <= tilt;
      end else if (state_r == ST_IACC) begin
        integ_r <= integ_cl;
      end
      // hold the result until taken
      if (state_r == ST_FIN && fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Serial datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          clr_r      <= in_tuser[0];
          err_neg_r  <= err_s[16];
          err_mag_r  <= err_s[16] ? 17'(-err_s) : 17'(err_s);
          diff_neg_r <= diff_s[16];
          diff_mag_r <= diff_s[16] ? 17'(-diff_s) : 17'(diff_s);
          fallen_r   <= (17'(tilt) > FALL_Q) || (17'(tilt) < -FALL_Q);
          acc_r      <= '0;
          mc_r       <= 45'(err_s[16] ? 17'(-err_s) : 17'(err_s));
          mp_r       <= ki_r;
          cnt_r      <= 6'd17;
        end
      end
      ST_IMUL1, ST_IMUL2, ST_PMUL, ST_DMUL1, ST_DMUL2, ST_DUTY: begin
        if (!cnt_last) begin
          // advance one multiplier bit
          acc_r <= mul_add;
          mc_r  <= {mc_r[43:0], 1'b0};
          mp_r  <= {1'b0, mp_r[17:1]};
          cnt_r <= cnt_r - 6'd1;
        end else begin
          unique case (state_r)
            ST_IMUL1: begin
              acc_r <= '0;
              mc_r  <= mul_add;
              mp_r  <= 18'(per_eff);
              cnt_r <= 6'd7;
            end
            ST_IMUL2: begin
              acc_r <= mul_add;
              rem_r <= '0;
              dvs_r <= MS_K[9:0];
              cnt_r <= 6'd44;
            end
            ST_PMUL: begin
              sum_r <= p_s + 48'(integ_r);
              acc_r <= '0;
              mc_r  <= 45'(diff_mag_r);
              mp_r  <= kd_r;
              cnt_r <= 6'd17;
            end
            ST_DMUL1: begin
              acc_r <= '0;
              mc_r  <= mul_add;
              mp_r  <= MS_K;
              cnt_r <= 6'd9;
            end
            ST_DMUL2: begin
              acc_r <= mul_add;
              rem_r <= '0;
              dvs_r <= {2'd0, per_eff};
              cnt_r <= 6'd44;
            end
            default: begin
              acc_r <= mul_add;
            end
          endcase
        end
      end
      ST_IDIV, ST_DDIV: begin
        rem_r <= div_ge ? div_sub[9:0] : div_try[9:0];
        acc_r <= {acc_r[43:0], div_ge};
        cnt_r <= cnt_r - 6'd1;
      end
      ST_IACC: begin
        acc_r <= '0;
        mc_r  <= 45'(err_mag_r);
        mp_r  <= kp_r;
        cnt_r <= 6'd17;
      end
      ST_DSUB: begin
        sum_r <= sum_r - d_s;
      end
      ST_DRV: begin
        drive_r <= sum_r[47] ? 11'(-{1'b0, drv_mag}) : {1'b0, drv_mag};
        rev_r   <= sum_r[47] && (drv_mag != 10'd0);
        acc_r   <= '0;
        mc_r    <= 45'(v_mag);
        mp_r    <= 18'(sf_r);
        cnt_r   <= 6'd8;
      end
      ST_FIN: begin
        if (fin_go) begin
          if (clr_r) begin
            out_data_r <= '0;
          end else begin
            out_data_r <= OUT_W'({fallen_r, (fallen_r ? {DUTY_BITS{1'b0}} : duty_v),
                                  rev_r, drive_r});
          end
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // clear command empties the integrator
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser[0]) |=> (integ_r == 27'sd0))
    else $error("integrator not cleared");

  // integrator stays within the widest clamp
  a_integ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (integ_r <= 27'sd67043328) && (integ_r >= -27'sd67043328))
    else $error("integrator out of range");

  // a fallen result never drives the motors
  a_fallen_duty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[12 + DUTY_BITS]) |-> (out_tdata[11 + DUTY_BITS:12] == '0))
    else $error("duty while fallen");
`endif

endmodule
